@@ sv/fib_pkg.sv @@
// Shared types, character codes and saturating helpers for the FASTA index builder.
`timescale 1ns / 1ps
`default_nettype none

package fib_pkg;

    localparam logic [7:0]  CH_GT   = 8'h3E;
    localparam logic [7:0]  CH_CR   = 8'h0D;
    localparam logic [7:0]  CH_LF   = 8'h0A;
    localparam logic [31:0] SAT_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } src_item_t;

    typedef struct packed {
        logic [31:0] name_offset;
        logic [31:0] name_length;
        logic [31:0] seq_offset;
        logic [31:0] seq_length;
        logic [31:0] bases_per_line;
        logic [31:0] bytes_per_line;
        logic        last_of_run;
    } rec_item_t;

    // Saturating 32-bit add.
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? SAT_MAX : s[31:0];
    endfunction

    // Saturating increment.
    function automatic logic [31:0] sat_inc(input logic [31:0] a);
        return (a == SAT_MAX) ? SAT_MAX : a + 32'd1;
    endfunction

endpackage

`default_nettype wire

@@ sv/fasta_index_builder.sv @@
// Top level of the FASTA index builder: byte parser, record state and result queue.
//
// Usage:
//   src channel: one FASTA text byte per transfer (src_valid/src_stall/src_data).
//     Set end_of_input on the final byte of a file; the parser then returns to
//     its reset state and the next byte starts a new file at offset 0.
//   rec channel: one faidx-style record per transfer (rec_valid/rec_stall/rec_data).
//     A record leaves when the next header's '>' arrives or when the file ends;
//     last_of_run marks the final record caused by one input byte (a '>' that
//     is also the last byte causes two).
//   A record enters the queue when its byte is taken and shows on rec after those ahead of it.
//   Throughput: one byte per cycle while src_stall is low. All per-byte work
//     (position, line and header tracking, base and line-shape counts) is
//     combinational logic between the state registers, so bytes follow back to back.
//   Records land in a 4-entry queue; src_stall rises while fewer than two
//     entries are free, so a stalled receiver backs up the byte stream once
//     three entries are taken. Records are never dropped.
//   Reset (rst_n low, asynchronous): position 0, at line start, no open record,
//     queue empty.
`timescale 1ns / 1ps
`default_nettype none

module fasta_index_builder
    import fib_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      src_valid,
    output logic           src_stall,
    input  wire src_item_t src_data,
    output logic           rec_valid,
    input  wire logic      rec_stall,
    output rec_item_t      rec_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // ------------------------------------------------------------------
    // Parser and open-record state
    // ------------------------------------------------------------------
    logic [31:0] byte_position_reg,       byte_position_next;
    logic        at_line_start_reg,       at_line_start_next;
    logic        in_header_line_reg,      in_header_line_next;
    logic [31:0] line_byte_count_reg,     line_byte_count_next;
    logic        line_saw_cr_reg,         line_saw_cr_next;
    logic        record_open_reg,         record_open_next;
    logic [31:0] open_name_offset_reg,    open_name_offset_next;
    logic [31:0] open_name_length_reg,    open_name_length_next;
    logic [31:0] open_seq_offset_reg,     open_seq_offset_next;
    logic [31:0] open_base_count_reg,     open_base_count_next;
    logic        line_shape_known_reg,    line_shape_known_next;
    logic [31:0] open_bases_per_line_reg, open_bases_per_line_next;
    logic [31:0] open_bytes_per_line_reg, open_bytes_per_line_next;

    // Result queue
    rec_item_t        fifo_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    logic        src_accept;
    logic        rec_accept;
    logic        emit_old;
    logic        emit_new;
    rec_item_t   rec_old;
    rec_item_t   rec_new;
    rec_item_t   wr_a;
    logic [1:0]  wr_cnt;

    assign src_accept = src_valid && !src_stall;
    assign rec_accept = rec_valid && !rec_stall;

    // One byte of parsing; mirrors the line/header rules in order:
    // header start or LF or content byte, then a line close, then end of file.
    always_comb
    begin
        logic        is_gt;
        logic        lf_branch;
        logic        do_fin;
        logic [31:0] content;

        is_gt     = at_line_start_reg && (src_data.data_byte == CH_GT);
        lf_branch = !is_gt && (src_data.data_byte == CH_LF);

        byte_position_next       = byte_position_reg;
        at_line_start_next       = at_line_start_reg;
        in_header_line_next      = in_header_line_reg;
        line_byte_count_next     = line_byte_count_reg;
        line_saw_cr_next         = line_saw_cr_reg;
        record_open_next         = record_open_reg;
        open_name_offset_next    = open_name_offset_reg;
        open_name_length_next    = open_name_length_reg;
        open_seq_offset_next     = open_seq_offset_reg;
        open_base_count_next     = open_base_count_reg;
        line_shape_known_next    = line_shape_known_reg;
        open_bases_per_line_next = open_bases_per_line_reg;
        open_bytes_per_line_next = open_bytes_per_line_reg;

        // Record closed by a new header: taken from the state before this byte.
        emit_old = is_gt && record_open_reg;
        rec_old.name_offset    = open_name_offset_reg;
        rec_old.name_length    = open_name_length_reg;
        rec_old.seq_offset     = open_seq_offset_reg;
        rec_old.seq_length     = open_base_count_reg;
        rec_old.bases_per_line = line_shape_known_reg ? open_bases_per_line_reg : '0;
        rec_old.bytes_per_line = line_shape_known_reg ? open_bytes_per_line_reg : '0;
        rec_old.last_of_run    = 1'b0;

        if (is_gt)
        begin
            // Open a fresh record; the '>' is the header's first byte.
            record_open_next         = 1'b1;
            open_name_offset_next    = sat_inc(byte_position_reg);
            open_name_length_next    = '0;
            open_seq_offset_next     = '0;
            open_base_count_next     = '0;
            line_shape_known_next    = 1'b0;
            open_bases_per_line_next = '0;
            open_bytes_per_line_next = '0;
            in_header_line_next      = 1'b1;
            line_byte_count_next     = 32'd1;
            line_saw_cr_next         = 1'b0;
            at_line_start_next       = 1'b0;
        end
        else if (lf_branch)
        begin
            at_line_start_next = 1'b1;
        end
        else
        begin
            line_byte_count_next = sat_inc(line_byte_count_reg);
            line_saw_cr_next     = (src_data.data_byte == CH_CR);
            at_line_start_next   = 1'b0;
        end

        // Close the line on LF, or on end of file in mid-line.
        do_fin  = lf_branch || (src_data.end_of_input && !at_line_start_next);
        content = line_byte_count_next - {31'd0, line_saw_cr_next};
        if (do_fin)
        begin
            if (in_header_line_next)
            begin
                open_name_length_next = (content != '0) ? content - 32'd1 : '0;
                open_seq_offset_next  = sat_inc(byte_position_reg);
                in_header_line_next   = 1'b0;
            end
            else if (record_open_next)
            begin
                open_base_count_next = sat_add(open_base_count_next, content);
                if (!line_shape_known_next && content != '0)
                begin
                    open_bases_per_line_next = content;
                    open_bytes_per_line_next = lf_branch ? sat_inc(line_byte_count_next)
                                                         : line_byte_count_next;
                    line_shape_known_next    = 1'b1;
                end
            end
            line_byte_count_next = '0;
            line_saw_cr_next     = 1'b0;
        end

        // Record closed by end of file: taken from the updated state.
        emit_new = src_data.end_of_input && record_open_next;
        rec_new.name_offset    = open_name_offset_next;
        rec_new.name_length    = open_name_length_next;
        rec_new.seq_offset     = open_seq_offset_next;
        rec_new.seq_length     = open_base_count_next;
        rec_new.bases_per_line = line_shape_known_next ? open_bases_per_line_next : '0;
        rec_new.bytes_per_line = line_shape_known_next ? open_bytes_per_line_next : '0;
        rec_new.last_of_run    = 1'b1;

        if (src_data.end_of_input)
        begin
            // Return to the power-on state for the next file.
            byte_position_next       = '0;
            at_line_start_next       = 1'b1;
            in_header_line_next      = 1'b0;
            line_byte_count_next     = '0;
            line_saw_cr_next         = 1'b0;
            record_open_next         = 1'b0;
            open_name_offset_next    = '0;
            open_name_length_next    = '0;
            open_seq_offset_next     = '0;
            open_base_count_next     = '0;
            line_shape_known_next    = 1'b0;
            open_bases_per_line_next = '0;
            open_bytes_per_line_next = '0;
        end
        else
        begin
            byte_position_next = sat_inc(byte_position_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg       <= '0;
            at_line_start_reg       <= 1'b1;
            in_header_line_reg      <= 1'b0;
            line_byte_count_reg     <= '0;
            line_saw_cr_reg         <= 1'b0;
            record_open_reg         <= 1'b0;
            open_name_offset_reg    <= '0;
            open_name_length_reg    <= '0;
            open_seq_offset_reg     <= '0;
            open_base_count_reg     <= '0;
            line_shape_known_reg    <= 1'b0;
            open_bases_per_line_reg <= '0;
            open_bytes_per_line_reg <= '0;
        end
        else if (src_accept)
        begin
            byte_position_reg       <= byte_position_next;
            at_line_start_reg       <= at_line_start_next;
            in_header_line_reg      <= in_header_line_next;
            line_byte_count_reg     <= line_byte_count_next;
            line_saw_cr_reg         <= line_saw_cr_next;
            record_open_reg         <= record_open_next;
            open_name_offset_reg    <= open_name_offset_next;
            open_name_length_reg    <= open_name_length_next;
            open_seq_offset_reg     <= open_seq_offset_next;
            open_base_count_reg     <= open_base_count_next;
            line_shape_known_reg    <= line_shape_known_next;
            open_bases_per_line_reg <= open_bases_per_line_next;
            open_bytes_per_line_reg <= open_bytes_per_line_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue: up to two writes per byte, at most one read per cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_cnt = '0;
        if (src_accept)
        begin
            wr_cnt = {1'b0, emit_old} + {1'b0, emit_new};
        end
        wr_a = rec_old;
        wr_a.last_of_run = !emit_new;
        if (!emit_old)
        begin
            wr_a = rec_new;
        end
        wr_ptr_next = wr_ptr_reg + PTR_W'(wr_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(rec_accept);
        count_next  = count_reg + CNT_W'(wr_cnt) - CNT_W'(rec_accept);
    end

    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= wr_a;
        end
        if (wr_cnt == 2'd2)
        begin
            fifo_mem[wr_ptr_reg + PTR_W'(1)] <= rec_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold off bytes unless two entries are free, whatever the receiver does.
    assign src_stall = (count_reg > CNT_W'(DEPTH - 2));
    assign rec_valid = (count_reg != '0);
    assign rec_data  = fifo_mem[rd_ptr_reg];

endmodule

`default_nettype wire
